FILE: hdl/pdm_pkg.sv
// Package for the PWM duty meter: shared types, fixed field widths and the
// seven-segment digit table. No dependencies.

package pdm_pkg;

	localparam int STAMP_W = 16;
	localparam int DUTY_W = 7;
	localparam int TENS_W = 7;
	localparam int ONES_W = 9;
	localparam int SPAN_W = 16;
	localparam int DIGIT_W = 4;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd99;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic [ONES_W-1:0] ones;
		logic [TENS_W-1:0] tens;
	} seg_out_t;

	function automatic logic [6:0] seg_pattern(input logic [DIGIT_W-1:0] d);
		logic [6:0] p;
		case (d)
			4'd0: p = 7'h3F;
			4'd1: p = 7'h06;
			4'd2: p = 7'h5B;
			4'd3: p = 7'h4F;
			4'd4: p = 7'h66;
			4'd5: p = 7'h6D;
			4'd6: p = 7'h7D;
			4'd7: p = 7'h07;
			4'd8: p = 7'h7F;
			4'd9: p = 7'h6F;
			default: p = 7'h00;
		endcase
		return p;
	endfunction

endpackage

FILE: hdl/pwm_duty_meter_seven_segment.sv
// Top level of the PWM duty meter: edge tracking, the measurement sequencer
// and the result register. Depends on pdm_pkg, pdm_alu and pdm_seg.

// Each request is one captured edge, stamp in s_tdata and polarity in s_tuser.
// An edge that does not close a measurement leaves the sequencer idle. The
// rising edge that closes a period starts a sequencer over one shared
// add/subtract unit: two span subtractions, a compare, two adds for the
// times-100 product and seven restoring divide steps; no new request is taken
// until the sequencer is back in idle. A zero period or a duty that saturates
// at 99 skips the product and the divide. A finished result waits in the
// output register and a new edge is taken meanwhile; the sequencer only
// stalls at its last step if that register is still full.

module pwm_duty_meter_seven_segment
	import pdm_pkg::*;
#(
	parameter int COUNTER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // stamp[15:0]
	input  logic        s_tuser,  // edge_rising[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// duty_percent[6:0], tens_segments[13:7], ones_segments[22:14],
	// high_span[38:23], period_span[54:39], zero fill[55]
	output logic [55:0] m_tdata,
	output logic        m_tuser   // period_zero[0]
);

	localparam int CW = COUNTER_BITS;
	localparam int W = COUNTER_BITS + DUTY_W;
	localparam logic [2:0] LAST_STEP = 3'(DUTY_W - 1);

	typedef enum logic [2:0] {
		PH_WAIT_RISE   = 3'b001,
		PH_WAIT_FALL   = 3'b010,
		PH_WAIT_PERIOD = 3'b100
	} phase_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_HIGH = 8'b0000_0010,
		S_PER  = 8'b0000_0100,
		S_CMP  = 8'b0000_1000,
		S_MUL1 = 8'b0001_0000,
		S_MUL2 = 8'b0010_0000,
		S_DIV  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} seq_state_t;

	seq_state_t         state_q;
	phase_t             phase_q;
	logic [CW-1:0]      rise_q;
	logic [CW-1:0]      fall_q;
	logic [CW-1:0]      stop_q;
	logic [CW-1:0]      high_q;
	logic [CW-1:0]      period_q;
	logic [W-1:0]       rem_q;
	logic [W-1:0]       dvs_q;
	logic [DUTY_W-1:0]  quot_q;
	logic [2:0]         step_q;
	logic               sat_q;
	logic               out_valid_q;
	logic [55:0]        out_data_q;
	logic               out_zero_q;

	logic [CW-1:0]      stamp;
	logic               accept;
	logic               out_free;
	logic               period_zero;
	logic [DUTY_W-1:0]  duty_sel;
	seg_out_t           segs;
	alu_op_t            alu_op;
	logic [W-1:0]       alu_a;
	logic [W-1:0]       alu_b;
	logic [W:0]         alu_res;

	assign stamp = CW'(s_tdata);
	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign period_zero = (period_q == '0);

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_zero_q;

	always_comb begin
		if (period_zero) begin
			duty_sel = '0;
		end else if (sat_q) begin
			duty_sel = DUTY_MAX;
		end else begin
			duty_sel = quot_q;
		end
	end

	always_comb begin
		alu_op = ALU_SUB;
		alu_a = W'(fall_q);
		alu_b = W'(rise_q);
		case (state_q)
			S_PER: begin
				alu_a = W'(stop_q);
			end
			S_CMP: begin
				alu_a = W'(high_q);
				alu_b = W'(period_q);
			end
			S_MUL1: begin
				alu_op = ALU_ADD;
				alu_a = W'(high_q) << 6;
				alu_b = W'(high_q) << 5;
			end
			S_MUL2: begin
				alu_op = ALU_ADD;
				alu_a = rem_q;
				alu_b = W'(high_q) << 2;
			end
			S_DIV: begin
				alu_a = rem_q;
				alu_b = dvs_q;
			end
			default: begin
				alu_op = ALU_SUB;
			end
		endcase
	end

	pdm_alu #(
		.W(W)
	) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.res(alu_res)
	);

	pdm_seg u_seg (
		.duty(duty_sel),
		.segs(segs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_WAIT_RISE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (phase_q)
							PH_WAIT_FALL: begin
								if (!s_tuser) begin
									phase_q <= PH_WAIT_PERIOD;
								end
							end
							PH_WAIT_PERIOD: begin
								if (s_tuser) begin
									phase_q <= PH_WAIT_RISE;
									state_q <= S_HIGH;
								end
							end
							default: begin
								phase_q <= s_tuser ? PH_WAIT_FALL : PH_WAIT_RISE;
							end
						endcase
					end
				end
				S_HIGH: state_q <= S_PER;
				S_PER:  state_q <= S_CMP;
				S_CMP: begin
					if (!alu_res[W] || period_zero) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_DIV;
				S_DIV: begin
					if (step_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (phase_q)
						PH_WAIT_FALL: begin
							if (!s_tuser) begin
								fall_q <= stamp;
							end
						end
						PH_WAIT_PERIOD: begin
							if (s_tuser) begin
								stop_q <= stamp;
							end
						end
						default: begin
							if (s_tuser) begin
								rise_q <= stamp;
							end
						end
					endcase
				end
			end
			S_HIGH: high_q <= alu_res[CW-1:0];
			S_PER:  period_q <= alu_res[CW-1:0];
			S_CMP:  sat_q <= !alu_res[W];
			S_MUL1: rem_q <= alu_res[W-1:0];
			S_MUL2: begin
				rem_q <= alu_res[W-1:0];
				dvs_q <= W'(period_q) << LAST_STEP;
				quot_q <= '0;
				step_q <= LAST_STEP;
			end
			S_DIV: begin
				if (!alu_res[W]) begin
					rem_q <= alu_res[W-1:0];
				end
				quot_q <= {quot_q[DUTY_W-2:0], !alu_res[W]};
				dvs_q <= dvs_q >> 1;
				step_q <= step_q - 3'd1;
			end
			S_DONE: begin
				if (out_free) begin
					out_data_q <= {1'b0, SPAN_W'(period_q), SPAN_W'(high_q),
						segs.ones, segs.tens, duty_sel};
					out_zero_q <= period_zero;
				end
			end
			default: begin
				sat_q <= sat_q;
			end
		endcase
	end

endmodule

FILE: hdl/pdm_alu.sv
// Shared add/subtract unit of the PWM duty meter; the borrow bit doubles as
// the compare result. Depends on pdm_pkg.

module pdm_alu
	import pdm_pkg::*;
#(
	parameter int W = 23
) (
	input  alu_op_t      op,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W:0]   res
);

	always_comb begin
		case (op)
			ALU_ADD: res = {1'b0, a} + {1'b0, b};
			ALU_SUB: res = {1'b0, a} - {1'b0, b};
			default: res = {1'b0, a} - {1'b0, b};
		endcase
	end

endmodule

FILE: hdl/pdm_seg.sv
// Splits a duty value below 100 into tens and ones and decodes both digits
// to seven-segment patterns. Depends on pdm_pkg.

module pdm_seg
	import pdm_pkg::*;
(
	input  logic [DUTY_W-1:0] duty,
	output seg_out_t          segs
);

	logic [14:0]        prod;
	logic [DIGIT_W-1:0] tens_d;
	logic [DUTY_W-1:0]  ones_full;
	logic [DIGIT_W-1:0] ones_d;
	logic [6:0]         ones_p;

	// Multiplying by 205 and dropping eleven bits divides by ten for values below 100.
	always_comb begin
		prod = 15'(duty) * 15'd205;
		tens_d = prod[14:11];
		ones_full = duty - DUTY_W'(tens_d) * 7'd10;
		ones_d = ones_full[DIGIT_W-1:0];
		ones_p = seg_pattern(ones_d);
		segs.tens = seg_pattern(tens_d);
		segs.ones = {1'b0, ones_p[6], 1'b0, ones_p[5:0]};
	end

endmodule
